[hw/rtl/cau_pkg.sv]
// Shared operation codes for the complex arithmetic unit.
package cau_pkg;

    localparam int MODE_WIDTH = 3;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_MAG = 3'd4
    } mode_t;

endpackage

[hw/rtl/complex_arithmetic_unit_top.sv]
// Complex arithmetic unit: fully pipelined add, subtract, multiply, divide and magnitude.
//
// One beat is accepted whenever start is high; busy is always low, since a new beat can
// enter in every clock cycle. Each beat yields exactly one result, shown on the result
// ports for one cycle while done is high. A beat passes the operand, product, sum and
// set-up registers, then the divider and root stages and the output register, before
// done rises; the defaults give Q16.16 operands.
// The receiver cannot stall, so nothing holds the pipeline.
// The depth is set by the restoring divider: one quotient bit per stage over the
// 2*DATA_WIDTH + FRAC_BITS bit dividend, with two such dividers running side by side for
// the real and imaginary parts. The integer square root for magnitude mode runs one root
// bit per stage in the first DATA_WIDTH of those stages. Every mode travels the same depth,
// so results leave in the order the beats came in. The front end registers the operands,
// forms the products (one W x W multiplier each), adds them, then prepares the dividend.
// Results outside the signed range saturate and raise overflow; a zero divisor gives zero
// parts and raises div_by_zero. Unused mode codes give an all-zero result.
module complex_arithmetic_unit_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [cau_pkg::MODE_WIDTH-1:0]        mode,
    input  logic signed [DATA_WIDTH-1:0]          first_re,
    input  logic signed [DATA_WIDTH-1:0]          first_im,
    input  logic signed [DATA_WIDTH-1:0]          second_re,
    input  logic signed [DATA_WIDTH-1:0]          second_im,
    output logic                                  done,
    output logic signed [DATA_WIDTH-1:0]          result_re,
    output logic signed [DATA_WIDTH-1:0]          result_im,
    output logic                                  div_by_zero,
    output logic                                  overflow
);

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int NW = PW + FRAC_BITS;
    localparam int MW = cau_pkg::MODE_WIDTH;

    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // The pipeline never pushes back.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: capture the operands.
    // ------------------------------------------------------------------
    logic                  s1_vld_reg;
    logic [MW-1:0]         s1_mode_reg;
    logic signed [W-1:0]   s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= mode;
        s1_a_reg    <= first_re;
        s1_b_reg    <= first_im;
        s1_c_reg    <= second_re;
        s1_d_reg    <= second_im;
    end

    // ------------------------------------------------------------------
    // Stage 2: products, and add/subtract finished outright.
    // ------------------------------------------------------------------
    logic signed [W-1:0]   s2_x_next, s2_y_next;
    logic signed [W:0]     s2_as_re, s2_as_im;
    logic [W-1:0]          s2_smp_re_next, s2_smp_im_next;
    logic                  s2_smp_ovf_next;
    logic                  as_ovf_re, as_ovf_im;

    logic                  s2_vld_reg;
    logic [MW-1:0]         s2_mode_reg;
    logic signed [PW-1:0]  s2_ac_reg, s2_bd_reg, s2_bc_reg, s2_ad_reg, s2_xx_reg, s2_yy_reg;
    logic [W-1:0]          s2_smp_re_reg, s2_smp_im_reg;
    logic                  s2_smp_ovf_reg;

    always_comb
    begin
        // Magnitude squares the first operand, divide squares the second.
        s2_x_next = (s1_mode_reg == cau_pkg::MODE_MAG) ? s1_a_reg : s1_c_reg;
        s2_y_next = (s1_mode_reg == cau_pkg::MODE_MAG) ? s1_b_reg : s1_d_reg;

        if (s1_mode_reg == cau_pkg::MODE_SUB)
        begin
            s2_as_re = {s1_a_reg[W-1], s1_a_reg} - {s1_c_reg[W-1], s1_c_reg};
            s2_as_im = {s1_b_reg[W-1], s1_b_reg} - {s1_d_reg[W-1], s1_d_reg};
        end
        else
        begin
            s2_as_re = {s1_a_reg[W-1], s1_a_reg} + {s1_c_reg[W-1], s1_c_reg};
            s2_as_im = {s1_b_reg[W-1], s1_b_reg} + {s1_d_reg[W-1], s1_d_reg};
        end

        as_ovf_re = s2_as_re[W] != s2_as_re[W-1];
        as_ovf_im = s2_as_im[W] != s2_as_im[W-1];

        s2_smp_re_next  = '0;
        s2_smp_im_next  = '0;
        s2_smp_ovf_next = 1'b0;
        if (s1_mode_reg == cau_pkg::MODE_ADD || s1_mode_reg == cau_pkg::MODE_SUB)
        begin
            s2_smp_re_next  = as_ovf_re ? (s2_as_re[W] ? SAT_MIN : SAT_MAX) : s2_as_re[W-1:0];
            s2_smp_im_next  = as_ovf_im ? (s2_as_im[W] ? SAT_MIN : SAT_MAX) : s2_as_im[W-1:0];
            s2_smp_ovf_next = as_ovf_re | as_ovf_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_mode_reg    <= s1_mode_reg;
        s2_ac_reg      <= PW'(s1_a_reg) * PW'(s1_c_reg);
        s2_bd_reg      <= PW'(s1_b_reg) * PW'(s1_d_reg);
        s2_bc_reg      <= PW'(s1_b_reg) * PW'(s1_c_reg);
        s2_ad_reg      <= PW'(s1_a_reg) * PW'(s1_d_reg);
        s2_xx_reg      <= PW'(s2_x_next) * PW'(s2_x_next);
        s2_yy_reg      <= PW'(s2_y_next) * PW'(s2_y_next);
        s2_smp_re_reg  <= s2_smp_re_next;
        s2_smp_im_reg  <= s2_smp_im_next;
        s2_smp_ovf_reg <= s2_smp_ovf_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: sums of products.
    // ------------------------------------------------------------------
    logic signed [PW:0]    s3_num_re_next, s3_num_im_next;

    logic                  s3_vld_reg;
    logic [MW-1:0]         s3_mode_reg;
    logic signed [PW:0]    s3_num_re_reg, s3_num_im_reg;
    logic [PW-1:0]         s3_sq_reg;
    logic [W-1:0]          s3_smp_re_reg, s3_smp_im_reg;
    logic                  s3_smp_ovf_reg;

    always_comb
    begin
        if (s2_mode_reg == cau_pkg::MODE_DIV)
        begin
            s3_num_re_next = {s2_ac_reg[PW-1], s2_ac_reg} + {s2_bd_reg[PW-1], s2_bd_reg};
            s3_num_im_next = {s2_bc_reg[PW-1], s2_bc_reg} - {s2_ad_reg[PW-1], s2_ad_reg};
        end
        else
        begin
            s3_num_re_next = {s2_ac_reg[PW-1], s2_ac_reg} - {s2_bd_reg[PW-1], s2_bd_reg};
            s3_num_im_next = {s2_bc_reg[PW-1], s2_bc_reg} + {s2_ad_reg[PW-1], s2_ad_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_mode_reg    <= s2_mode_reg;
        s3_num_re_reg  <= s3_num_re_next;
        s3_num_im_reg  <= s3_num_im_next;
        // Both squares are non-negative, so their sum fits unsigned in PW bits.
        s3_sq_reg      <= s2_xx_reg + s2_yy_reg;
        s3_smp_re_reg  <= s2_smp_re_reg;
        s3_smp_im_reg  <= s2_smp_im_reg;
        s3_smp_ovf_reg <= s2_smp_ovf_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: finish multiply, set up the dividends.
    // ------------------------------------------------------------------
    logic signed [PW:0]    mul_re, mul_im;
    logic                  mul_fit_re, mul_fit_im;
    logic [PW:0]           mag_re_full, mag_im_full;
    logic [W-1:0]          s4_smp_re_next, s4_smp_im_next;
    logic                  s4_smp_ovf_next;

    always_comb
    begin
        mul_re     = s3_num_re_reg >>> FRAC_BITS;
        mul_im     = s3_num_im_reg >>> FRAC_BITS;
        mul_fit_re = (&mul_re[PW:W-1]) | ~(|mul_re[PW:W-1]);
        mul_fit_im = (&mul_im[PW:W-1]) | ~(|mul_im[PW:W-1]);

        mag_re_full = s3_num_re_reg[PW] ? -s3_num_re_reg : s3_num_re_reg;
        mag_im_full = s3_num_im_reg[PW] ? -s3_num_im_reg : s3_num_im_reg;

        if (s3_mode_reg == cau_pkg::MODE_MUL)
        begin
            s4_smp_re_next  = mul_fit_re ? mul_re[W-1:0] : (mul_re[PW] ? SAT_MIN : SAT_MAX);
            s4_smp_im_next  = mul_fit_im ? mul_im[W-1:0] : (mul_im[PW] ? SAT_MIN : SAT_MAX);
            s4_smp_ovf_next = ~mul_fit_re | ~mul_fit_im;
        end
        else
        begin
            s4_smp_re_next  = s3_smp_re_reg;
            s4_smp_im_next  = s3_smp_im_reg;
            s4_smp_ovf_next = s3_smp_ovf_reg;
        end
    end

    // Per-stage pipeline of the dividers and the square root; index 0 is stage 4.
    logic              vld_reg     [0:NW];
    logic [MW-1:0]     mode_reg    [0:NW];
    logic              dz_reg      [0:NW];
    logic              neg_re_reg  [0:NW];
    logic              neg_im_reg  [0:NW];
    logic [W-1:0]      smp_re_reg  [0:NW];
    logic [W-1:0]      smp_im_reg  [0:NW];
    logic              smp_ovf_reg [0:NW];
    logic [PW-1:0]     den_reg     [0:NW];
    logic [NW-1:0]     dnd_re_reg  [0:NW];
    logic [NW-1:0]     dnd_im_reg  [0:NW];
    logic [PW-1:0]     rem_re_reg  [0:NW];
    logic [PW-1:0]     rem_im_reg  [0:NW];
    logic [W-1:0]      quo_re_reg  [0:NW];
    logic [W-1:0]      quo_im_reg  [0:NW];
    logic              big_re_reg  [0:NW];
    logic              big_im_reg  [0:NW];
    logic [PW-1:0]     sq_reg      [0:NW];
    logic [W+1:0]      srem_reg    [0:NW];
    logic [W-1:0]      root_reg    [0:NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg[0]    <= s3_mode_reg;
        dz_reg[0]      <= (s3_sq_reg == '0);
        neg_re_reg[0]  <= s3_num_re_reg[PW];
        neg_im_reg[0]  <= s3_num_im_reg[PW];
        smp_re_reg[0]  <= s4_smp_re_next;
        smp_im_reg[0]  <= s4_smp_im_next;
        smp_ovf_reg[0] <= s4_smp_ovf_next;
        den_reg[0]     <= s3_sq_reg;
        // Magnitude is at most 2^(PW-1), so it fits PW bits unsigned.
        dnd_re_reg[0]  <= NW'(mag_re_full[PW-1:0]) << FRAC_BITS;
        dnd_im_reg[0]  <= NW'(mag_im_full[PW-1:0]) << FRAC_BITS;
        rem_re_reg[0]  <= '0;
        rem_im_reg[0]  <= '0;
        quo_re_reg[0]  <= '0;
        quo_im_reg[0]  <= '0;
        big_re_reg[0]  <= 1'b0;
        big_im_reg[0]  <= 1'b0;
        sq_reg[0]      <= s3_sq_reg;
        srem_reg[0]    <= '0;
        root_reg[0]    <= '0;
    end

    // ------------------------------------------------------------------
    // Divider and root stages: one quotient bit, and one root bit while
    // root bits remain, per stage.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NW; i++)
    begin : g_step
        logic [PW:0]   trial_re, trial_im;
        logic          take_re, take_im;
        logic [PW-1:0] rem_re_next, rem_im_next;
        logic [W+1:0]  strial, srem_sh;
        logic [W+1:0]  srem_next;
        logic [W-1:0]  root_next;
        logic [PW-1:0] sq_next;

        always_comb
        begin
            trial_re    = {rem_re_reg[i], dnd_re_reg[i][NW-1]};
            trial_im    = {rem_im_reg[i], dnd_im_reg[i][NW-1]};
            take_re     = trial_re >= {1'b0, den_reg[i]};
            take_im     = trial_im >= {1'b0, den_reg[i]};
            rem_re_next = take_re ? PW'(trial_re - {1'b0, den_reg[i]}) : trial_re[PW-1:0];
            rem_im_next = take_im ? PW'(trial_im - {1'b0, den_reg[i]}) : trial_im[PW-1:0];

            // Bring down two radicand bits, test root*4+1 against the remainder.
            srem_sh   = {srem_reg[i][W-1:0], sq_reg[i][PW-1:PW-2]};
            strial    = {root_reg[i], 2'b01};
            srem_next = srem_reg[i];
            root_next = root_reg[i];
            sq_next   = sq_reg[i];
            if (i < W)
            begin
                sq_next = sq_reg[i] << 2;
                if (srem_sh >= strial)
                begin
                    srem_next = srem_sh - strial;
                    root_next = {root_reg[i][W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh;
                    root_next = {root_reg[i][W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            mode_reg[i+1]    <= mode_reg[i];
            dz_reg[i+1]      <= dz_reg[i];
            neg_re_reg[i+1]  <= neg_re_reg[i];
            neg_im_reg[i+1]  <= neg_im_reg[i];
            smp_re_reg[i+1]  <= smp_re_reg[i];
            smp_im_reg[i+1]  <= smp_im_reg[i];
            smp_ovf_reg[i+1] <= smp_ovf_reg[i];
            den_reg[i+1]     <= den_reg[i];
            dnd_re_reg[i+1]  <= dnd_re_reg[i] << 1;
            dnd_im_reg[i+1]  <= dnd_im_reg[i] << 1;
            rem_re_reg[i+1]  <= rem_re_next;
            rem_im_reg[i+1]  <= rem_im_next;
            // Keep the low quotient bits; remember any bit that leaves the top.
            quo_re_reg[i+1]  <= {quo_re_reg[i][W-2:0], take_re};
            quo_im_reg[i+1]  <= {quo_im_reg[i][W-2:0], take_im};
            big_re_reg[i+1]  <= big_re_reg[i] | quo_re_reg[i][W-1];
            big_im_reg[i+1]  <= big_im_reg[i] | quo_im_reg[i][W-1];
            sq_reg[i+1]      <= sq_next;
            srem_reg[i+1]    <= srem_next;
            root_reg[i+1]    <= root_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturate and select by mode.
    // ------------------------------------------------------------------
    logic [W-1:0]  q_re, q_im;
    logic          dv_ovf_re, dv_ovf_im;
    logic [W-1:0]  dv_re, dv_im;
    logic [W-1:0]  out_re_next, out_im_next;
    logic          out_dz_next, out_ovf_next;

    logic          done_reg;
    logic [W-1:0]  result_re_reg, result_im_reg;
    logic          div_by_zero_reg, overflow_reg;

    always_comb
    begin
        q_re = quo_re_reg[NW];
        q_im = quo_im_reg[NW];

        // A negative quotient of exactly 2^(W-1) still fits as the minimum.
        if (neg_re_reg[NW])
        begin
            dv_ovf_re = big_re_reg[NW] | (q_re[W-1] & (|q_re[W-2:0]));
            dv_re     = dv_ovf_re ? SAT_MIN : -q_re;
        end
        else
        begin
            dv_ovf_re = big_re_reg[NW] | q_re[W-1];
            dv_re     = dv_ovf_re ? SAT_MAX : q_re;
        end

        if (neg_im_reg[NW])
        begin
            dv_ovf_im = big_im_reg[NW] | (q_im[W-1] & (|q_im[W-2:0]));
            dv_im     = dv_ovf_im ? SAT_MIN : -q_im;
        end
        else
        begin
            dv_ovf_im = big_im_reg[NW] | q_im[W-1];
            dv_im     = dv_ovf_im ? SAT_MAX : q_im;
        end

        out_re_next  = smp_re_reg[NW];
        out_im_next  = smp_im_reg[NW];
        out_dz_next  = 1'b0;
        out_ovf_next = smp_ovf_reg[NW];

        case (mode_reg[NW])
            cau_pkg::MODE_DIV:
            begin
                if (dz_reg[NW])
                begin
                    out_re_next  = '0;
                    out_im_next  = '0;
                    out_dz_next  = 1'b1;
                    out_ovf_next = 1'b0;
                end
                else
                begin
                    out_re_next  = dv_re;
                    out_im_next  = dv_im;
                    out_ovf_next = dv_ovf_re | dv_ovf_im;
                end
            end
            cau_pkg::MODE_MAG:
            begin
                out_re_next  = root_reg[NW][W-1] ? SAT_MAX : root_reg[NW];
                out_im_next  = '0;
                out_ovf_next = root_reg[NW][W-1];
            end
            default:
            begin
                out_re_next  = smp_re_reg[NW];
                out_im_next  = smp_im_reg[NW];
                out_ovf_next = smp_ovf_reg[NW];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        result_re_reg   <= out_re_next;
        result_im_reg   <= out_im_next;
        div_by_zero_reg <= out_dz_next;
        overflow_reg    <= out_ovf_next;
    end

    assign done        = done_reg;
    assign result_re   = result_re_reg;
    assign result_im   = result_im_reg;
    assign div_by_zero = div_by_zero_reg;
    assign overflow    = overflow_reg;

endmodule

[hw/rtl/cau_checker.sv]
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [cau_pkg::MODE_WIDTH-1:0]     mode,
    input logic                               done,
    input logic [DATA_WIDTH-1:0]              result_re,
    input logic [DATA_WIDTH-1:0]              result_im,
    input logic                               div_by_zero,
    input logic                               overflow
);

    localparam int LATENCY = 2 * DATA_WIDTH + FRAC_BITS + 5;
    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Every result beat traces back to an earlier accepted beat.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without a matching accepted beat");

    // Divide by zero never reports overflow.
    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> !overflow)
        else $error("div_by_zero with overflow");

    // Divide by zero returns zero parts.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> (result_re == '0 && result_im == '0))
        else $error("div_by_zero with nonzero result");

    // Overflow leaves at least one part at a limit.
    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (result_re == SAT_MAX || result_re == SAT_MIN ||
                                result_im == SAT_MAX || result_im == SAT_MIN))
        else $error("overflow without a saturated part");

    // A divide by zero comes only from a divide beat.
    a_dz_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && div_by_zero) |-> ($past(mode, LATENCY) == cau_pkg::MODE_DIV))
        else $error("div_by_zero outside divide mode");

endmodule

bind complex_arithmetic_unit_top cau_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .done        (done),
    .result_re   (result_re),
    .result_im   (result_im),
    .div_by_zero (div_by_zero),
    .overflow    (overflow)
);
